// File: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the shadow call stack tracker.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int PC_W          = 16;
  localparam int ENTRY_W       = PC_W + 1;
  localparam int DEF_STACK_DEPTH = 32;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // One stack entry: return-back tag above the address.
  typedef struct packed {
    logic            ret_back;
    logic [PC_W-1:0] pc;
  } sst_entry_t;

endpackage

// File: rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// File: rtl/shadow_call_stack_tracker.sv
// A clear pushes the test return address, then the current PC. A step pushes or pops (a
// return on a call pops twice, fetching the new top entry if any remain), then does the
// interrupt push and the pairs' second halves. An unused code only gives its result. A read
// presents each entry, then the last PC. One input transaction is handled at a time; the
// single-port stack RAM takes one push, pop or read per cycle. Reset (rst_n low, synchronous)
// empties the stack, clears the last PC, returned flag and test return address, not the RAM.
// ----------------------------------------------------------------------------
// shadow_call_stack_tracker
// Tracks calls, returns and interrupt entries in a shadow stack held in RAM.
// ----------------------------------------------------------------------------
module shadow_call_stack_tracker
  import sst_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  // configuration port
  input  logic            cfg_we,
  input  logic [PC_W-1:0] cfg_wdata,
  // input channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_operation,
  input  logic [PC_W-1:0] in_pc_before,
  input  logic [PC_W-1:0] in_pc_after,
  input  logic            in_is_call,
  input  logic            in_is_return,
  input  logic            in_is_interrupt,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PC_W-1:0] out_address,
  output logic            out_last,
  output logic            out_returned,
  output logic [1:0]      out_status
);

  // Count needs to hold the depth itself; the RAM address only the entries.
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR1 = 4'd1;   // push call(test return address)
  localparam logic [3:0] S_CLR2 = 4'd2;   // push call(current PC)
  localparam logic [3:0] S_A    = 4'd3;   // call push, first pop, or return-back push
  localparam logic [3:0] S_A2   = 4'd4;   // second pop, fetch the new top entry
  localparam logic [3:0] S_RD   = 4'd5;   // new top entry arrives from RAM
  localparam logic [3:0] S_B    = 4'd6;   // interrupt push, sample "will return"
  localparam logic [3:0] S_C    = 4'd7;   // second half of call or return-back pair
  localparam logic [3:0] S_D    = 4'd8;   // second half of interrupt pair
  localparam logic [3:0] S_OUT  = 4'd9;   // single result transaction
  localparam logic [3:0] S_RQ   = 4'd10;  // read stream: request entry
  localparam logic [3:0] S_RV   = 4'd11;  // read stream: present entry
  localparam logic [3:0] S_LAST = 4'd12;  // read stream: trailing last PC

  // Control state.
  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            top_call_r, top_call_nxt;   // top entry exists and is a call
  logic            returned_r, returned_nxt;
  logic [PC_W-1:0] last_pc_r, last_pc_nxt;
  logic [PC_W-1:0] tra_r;
  logic            back_r, back_nxt;
  logic            irq_r, irq_nxt;
  logic            will_r, will_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Latched input transaction.
  logic [1:0]      op_r;
  logic [PC_W-1:0] pcb_r, pca_r;
  logic            call_r, ret_r, int_r;

  // Result register payload.
  logic [PC_W-1:0] out_address_r;
  logic            out_last_r, out_returned_r;
  logic [1:0]      out_status_r;

  // Per-cycle stack operations and RAM port.
  logic            push_en, pop_en, push_tag;
  logic [PC_W-1:0] push_pc;
  logic            out_load, slot_free;
  logic [PC_W-1:0] load_address;
  logic            load_last, load_returned;
  logic [1:0]      load_status;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  sst_entry_t      ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  logic            in_accept;
  logic            top_after;
  logic [CW-1:0]   nc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The result register is free now or is emptied at this edge.
  assign slot_free = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_address  = out_address_r;
  assign out_last     = out_last_r;
  assign out_returned = out_returned_r;
  assign out_status   = out_status_r;

  assign ram_rdata = sst_entry_t'(ram_rdata_raw);

  sst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata_raw)
  );

  // Sequencer: decides which push, pop or read happens in each cycle, then a
  // common block carries out the push or pop against the count and flags
  // overflow or underflow. Only the first error of a step is reported.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    top_call_nxt  = top_call_r;
    returned_nxt  = returned_r;
    last_pc_nxt   = last_pc_r;
    back_nxt      = back_r;
    irq_nxt       = irq_r;
    will_nxt      = will_r;
    status_nxt    = status_r;
    push_en       = 1'b0;
    pop_en        = 1'b0;
    push_tag      = 1'b0;
    push_pc       = pcb_r;
    out_load      = 1'b0;
    load_address  = '0;
    load_last     = 1'b1;
    load_returned = returned_r;
    load_status   = ST_OK;
    ram_we        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = '0;
    nc            = '0;
    top_after     = top_call_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          status_nxt = ST_OK;
          back_nxt   = 1'b0;
          irq_nxt    = 1'b0;
          will_nxt   = 1'b0;
          idx_nxt    = '0;
          case (in_operation)
            OP_CLEAR: begin
              count_nxt    = '0;
              top_call_nxt = 1'b0;
              state_nxt    = S_CLR1;
            end
            OP_STEP: begin
              state_nxt = S_A;
            end
            OP_READ: begin
              state_nxt = (count_r == '0) ? S_LAST : S_RQ;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_CLR1: begin
        push_en   = 1'b1;
        push_pc   = tra_r;
        state_nxt = S_CLR2;
      end
      S_CLR2: begin
        push_en   = 1'b1;
        push_pc   = pcb_r;
        state_nxt = S_OUT;
      end
      S_A: begin
        state_nxt = S_B;
        if (call_r) begin
          push_en = 1'b1;
        end else if (ret_r) begin
          if (top_call_r) begin
            pop_en    = 1'b1;
            state_nxt = S_A2;
          end else begin
            push_en  = 1'b1;
            push_tag = 1'b1;
            back_nxt = 1'b1;
          end
        end
      end
      S_A2: begin
        // Second pop; the new top entry has to come back from RAM.
        pop_en = 1'b1;
        nc     = (count_r == '0) ? '0 : count_r - CW'(1);
        if (nc != '0) begin
          ram_addr  = AW'(nc - CW'(1));
          state_nxt = S_RD;
        end else begin
          top_call_nxt = 1'b0;
          state_nxt    = S_B;
        end
      end
      S_RD: begin
        top_call_nxt = !ram_rdata.ret_back;
        state_nxt    = S_B;
      end
      S_B: begin
        if (!returned_r && int_r) begin
          push_en = 1'b1;
          irq_nxt = 1'b1;
          if (count_r < DEPTH_C) begin
            top_after = 1'b1;
          end
        end
        will_nxt  = ret_r && top_after;
        state_nxt = S_C;
      end
      S_C: begin
        push_pc = pca_r;
        if (call_r) begin
          push_en = 1'b1;
        end else if (back_r) begin
          push_en  = 1'b1;
          push_tag = 1'b1;
        end
        state_nxt = S_D;
      end
      S_D: begin
        push_pc   = pca_r;
        push_en   = irq_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          load_status = status_r;
          if (op_r == OP_STEP) begin
            load_returned = will_r;
            returned_nxt  = will_r;
            last_pc_nxt   = pcb_r;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RQ: begin
        ram_addr = idx_r[AW-1:0];
        if (slot_free) begin
          state_nxt = S_RV;
        end
      end
      S_RV: begin
        // The request was only made once the result register would be free.
        out_load     = 1'b1;
        load_address = ram_rdata.pc;
        load_last    = 1'b0;
        idx_nxt      = idx_r + CW'(1);
        state_nxt    = (idx_r + CW'(1) == count_r) ? S_LAST : S_RQ;
      end
      S_LAST: begin
        if (slot_free) begin
          out_load     = 1'b1;
          load_address = last_pc_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push_en) begin
      if (count_r < DEPTH_C) begin
        ram_we             = 1'b1;
        ram_addr           = count_r[AW-1:0];
        ram_wdata.ret_back = push_tag;
        ram_wdata.pc       = push_pc;
        count_nxt          = count_r + CW'(1);
        top_call_nxt       = !push_tag;
      end else if (status_r == ST_OK) begin
        status_nxt = ST_OVERFLOW;
      end
    end

    if (pop_en) begin
      if (count_r != '0) begin
        count_nxt = count_r - CW'(1);
      end else if (status_r == ST_OK) begin
        status_nxt = ST_UNDERFLOW;
      end
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      top_call_r  <= 1'b0;
      returned_r  <= 1'b0;
      last_pc_r   <= '0;
      tra_r       <= '0;
      back_r      <= 1'b0;
      irq_r       <= 1'b0;
      will_r      <= 1'b0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      top_call_r  <= top_call_nxt;
      returned_r  <= returned_nxt;
      last_pc_r   <= last_pc_nxt;
      back_r      <= back_nxt;
      irq_r       <= irq_nxt;
      will_r      <= will_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tra_r <= cfg_wdata;
      end
    end
  end

  // Transaction payload and result payload need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_operation;
      pcb_r  <= in_pc_before;
      pca_r  <= in_pc_after;
      call_r <= in_is_call;
      ret_r  <= in_is_return;
      int_r  <= in_is_interrupt;
    end
    if (out_load) begin
      out_address_r  <= load_address;
      out_last_r     <= load_last;
      out_returned_r <= load_returned;
      out_status_r   <= load_status;
    end
  end

`ifndef SYNTHESIS
  // The stack never holds more entries than the RAM has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stack count beyond depth");

  // A RAM write only ever lands on a free entry.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (count_r < DEPTH_C))
    else $error("stack write with a full stack");

  // A clear always leaves exactly two entries behind.
  a_clear_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && op_r == OP_CLEAR) |-> (count_r == CW'(2)))
    else $error("clear did not leave two entries");

  // An error status only ever goes out on a final result.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_last_r)
    else $error("error status on a non-final result");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the shadow call stack tracker. A queue-fed driver
// sends clear, step, read and unused-code transactions in random bursts while
// the result side stalls on its own pattern. Every accepted input transaction
// is run through a shadow copy of the stack held in the testbench, and every
// accepted result transaction is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
  import sst_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;
  // The block answers code 3 with a single empty result and changes nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  // One input transaction, as the driver presents it.
  typedef struct packed {
    logic [1:0]      op;
    logic [PC_W-1:0] pc_before;
    logic [PC_W-1:0] pc_after;
    logic            is_call;
    logic            is_return;
    logic            is_interrupt;
  } instr_t;

  // One result transaction.
  typedef struct packed {
    logic [PC_W-1:0] address;
    logic            last;
    logic            returned;
    logic [1:0]      status;
  } beat_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Everything starts at a
  // known value so that nothing reaches the block as X.
  // --------------------------------------------------------------------------
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [PC_W-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      in_operation = OP_CLEAR;
  logic [PC_W-1:0] in_pc_before = '0;
  logic [PC_W-1:0] in_pc_after = '0;
  logic            in_is_call = 1'b0;
  logic            in_is_return = 1'b0;
  logic            in_is_interrupt = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [PC_W-1:0] out_address;
  logic            out_last;
  logic            out_returned;
  logic [1:0]      out_status;

  always #5 clk = ~clk;

  shadow_call_stack_tracker #(
    .STACK_DEPTH (DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_pc_before    (in_pc_before),
    .in_pc_after     (in_pc_after),
    .in_is_call      (in_is_call),
    .in_is_return    (in_is_return),
    .in_is_interrupt (in_is_interrupt),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_address     (out_address),
    .out_last        (out_last),
    .out_returned    (out_returned),
    .out_status      (out_status)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the tracker's state. Entries at or above shadow_depth are
  // never looked at, so the unwritten part of the array may stay X.
  // --------------------------------------------------------------------------
  sst_entry_t      shadow_stack [DEPTH];
  int              shadow_depth = 0;
  logic [PC_W-1:0] shadow_last_pc = '0;
  logic            shadow_returned = 1'b0;
  logic [PC_W-1:0] shadow_test_ret = '0;
  logic [1:0]      shadow_status = ST_OK;

  instr_t stim_q [$];       // transactions still to be driven
  beat_t  awaited [$];      // results predicted but not yet seen
  bit     in_pending = 1'b0; // the driver holds a transaction not yet accepted
  int     mismatch_count = 0;

  // Appends a transaction to the stimulus queue.
  function automatic void queue_stim(instr_t it);
    stim_q.insert(stim_q.size(), it);
  endfunction

  // Appends a predicted result to the queue of awaited ones.
  function automatic void queue_beat(beat_t b);
    awaited.insert(awaited.size(), b);
  endfunction

  // Only the first error of a step is reported, so later ones leave the
  // status alone.
  function automatic void shadow_push(logic ret_back, logic [PC_W-1:0] pc);
    if (shadow_depth >= DEPTH) begin
      if (shadow_status == ST_OK) shadow_status = ST_OVERFLOW;
    end else begin
      shadow_stack[shadow_depth].ret_back = ret_back;
      shadow_stack[shadow_depth].pc       = pc;
      shadow_depth++;
    end
  endfunction

  function automatic void shadow_pop();
    if (shadow_depth == 0) begin
      if (shadow_status == ST_OK) shadow_status = ST_UNDERFLOW;
    end else begin
      shadow_depth--;
    end
  endfunction

  // An empty stack has no call on top.
  function automatic bit top_holds_call();
    return shadow_depth != 0 && !shadow_stack[shadow_depth-1].ret_back;
  endfunction

  function automatic beat_t make_beat(logic [PC_W-1:0] address, logic last,
                                      logic [1:0] status);
    beat_t b;
    b.address  = address;
    b.last     = last;
    b.returned = shadow_returned;
    b.status   = status;
    return b;
  endfunction

  // Applies one accepted transaction to the shadow state and queues the
  // results that the block must deliver for it.
  function automatic void advance_shadow_stack(instr_t it);
    bit back_taken;
    bit irq_taken;
    bit will_return;
    back_taken = 1'b0;
    irq_taken  = 1'b0;
    case (it.op)
      OP_CLEAR: begin
        // Clear keeps the last PC and the returned flag as they were.
        shadow_depth  = 0;
        shadow_status = ST_OK;
        shadow_push(1'b0, shadow_test_ret);
        shadow_push(1'b0, it.pc_before);
        queue_beat(make_beat('0, 1'b1, ST_OK));
      end
      OP_STEP: begin
        shadow_status = ST_OK;
        // A call wins over a return when both flags are set.
        if (it.is_call) begin
          shadow_push(1'b0, it.pc_before);
        end else if (it.is_return) begin
          if (top_holds_call()) begin
            shadow_pop();
            shadow_pop();
          end else begin
            shadow_push(1'b1, it.pc_before);
            back_taken = 1'b1;
          end
        end
        // An interrupt straight after a completed return is not tracked.
        if (!shadow_returned && it.is_interrupt) begin
          shadow_push(1'b0, it.pc_before);
          irq_taken = 1'b1;
        end
        will_return = it.is_return && top_holds_call();
        if (it.is_call) shadow_push(1'b0, it.pc_after);
        if (back_taken) shadow_push(1'b1, it.pc_after);
        if (irq_taken) shadow_push(1'b0, it.pc_after);
        shadow_returned = will_return;
        shadow_last_pc  = it.pc_before;
        queue_beat(make_beat('0, 1'b1, shadow_status));
      end
      OP_READ: begin
        // Bottom entry first, the tag is not shown, then the last PC.
        for (int i = 0; i < shadow_depth; i++) begin
          queue_beat(make_beat(shadow_stack[i].pc, 1'b0, ST_OK));
        end
        queue_beat(make_beat(shadow_last_pc, 1'b1, ST_OK));
      end
      default: begin
        queue_beat(make_beat('0, 1'b1, ST_OK));
      end
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge. The result side
  // is checked before the input side is predicted, so a result that turns up
  // with nothing outstanding is always caught as unexpected.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    beat_t  got;
    beat_t  want;
    instr_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.address  = out_address;
        got.last     = out_last;
        got.returned = out_returned;
        got.status   = out_status;
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("result with none expected: addr=%h last=%b ret=%b st=%0d",
                                  got.address, got.last, got.returned, got.status));
        end else begin
          want = awaited.pop_front();
          if (got.address !== want.address || got.last !== want.last ||
              got.returned !== want.returned || got.status !== want.status) begin
            flag_mismatch($sformatf(
              "expected addr=%h last=%b ret=%b st=%0d, got addr=%h last=%b ret=%b st=%0d",
              want.address, want.last, want.returned, want.status,
              got.address, got.last, got.returned, got.status));
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.op           = in_operation;
        seen.pc_before    = in_pc_before;
        seen.pc_after     = in_pc_after;
        seen.is_call      = in_is_call;
        seen.is_return    = in_is_return;
        seen.is_interrupt = in_is_interrupt;
        advance_shadow_stack(seen);
        in_pending = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: sends transactions in bursts of random length separated by random
  // gaps. A transaction, once presented, is held until it has been accepted.
  // Valid is assigned at most once per falling edge, so back-to-back
  // transactions keep it high without a glitch.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    instr_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_pending) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        nxt = stim_q.pop_front();
        in_operation    <= nxt.op;
        in_pc_before    <= nxt.pc_before;
        in_pc_after     <= nxt.pc_after;
        in_is_call      <= nxt.is_call;
        in_is_return    <= nxt.is_return;
        in_is_interrupt <= nxt.is_interrupt;
        in_valid        <= 1'b1;
        in_pending = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          // About a third of the bursts follow on with no gap at all.
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: runs of random length, each in one of four
  // styles - never stalling, stalling now and then, stalling half the time,
  // or a fixed rhythm, stalled five eighths of the time.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_run = 0;

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(4, 40);
    end
    stall_run--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ((stall_run % 8) < 5);
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic instr_t make_instr(logic [1:0] op, logic [PC_W-1:0] pc_before,
                                        logic [PC_W-1:0] pc_after, logic is_call,
                                        logic is_return, logic is_interrupt);
    instr_t it;
    it.op           = op;
    it.pc_before    = pc_before;
    it.pc_after     = pc_after;
    it.is_call      = is_call;
    it.is_return    = is_return;
    it.is_interrupt = is_interrupt;
    return it;
  endfunction

  // Addresses lean towards the two ends of the range now and then.
  function automatic logic [PC_W-1:0] rand_pc();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PC_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // A random single flag.
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Register writes are only issued while the block has nothing in flight.
  task automatic write_test_ret(logic [PC_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    shadow_test_ret = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every transaction has been sent and answered, then lets the block settle.
  task automatic wait_drained();
    while (stim_q.size() != 0 || in_pending || awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Hand-picked sequence: a read of an empty stack, returns onto an empty stack
  // and onto return-back entries, a matched return, interrupts with and
  // without a preceding return, call and return together, the unused code,
  // and finally a stack filled past its top and read out in full.
  task automatic add_directed();
    queue_stim(make_instr(OP_READ, '0, '0, 1'b0, 1'b0, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0));
    queue_stim(make_instr(OP_CLEAR, 16'h1234, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    queue_stim(make_instr(OP_STEP, 16'h1000, 16'h2000, 1'b1, 1'b0, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'h2010, 16'h1003, 1'b0, 1'b1, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'h1003, 16'hFFFA, 1'b0, 1'b0, 1'b1));
    queue_stim(make_instr(OP_STEP, 16'h1004, 16'hFFFE, 1'b0, 1'b0, 1'b1));
    queue_stim(make_instr(OP_STEP, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1));
    queue_stim(make_instr(OP_READ, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    queue_stim(make_instr(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    queue_stim(make_instr(OP_STEP, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0));
    queue_stim(make_instr(OP_CLEAR, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'h0300, 16'h0301, 1'b0, 1'b1, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'h0400, 16'h0401, 1'b0, 1'b1, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'h0500, 16'h0501, 1'b0, 1'b1, 1'b0));
    queue_stim(make_instr(OP_STEP, 16'h0600, 16'h0601, 1'b0, 1'b1, 1'b1));
    for (int i = 0; i < 7; i++) begin
      queue_stim(make_instr(OP_STEP, rand_pc(), rand_pc(), 1'b1, 1'b0, 1'b1));
    end
    queue_stim(make_instr(OP_READ, '0, '0, 1'b0, 1'b0, 1'b0));
  endtask

  // Random part. Most of it is properly nested call and return runs with
  // random addresses, which is what drives the returned flag and the pops;
  // the rest is clears, reads, the unused code and steps with random flags.
  task automatic add_random(int count);
    int made;
    int kind;
    int nest;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        queue_stim(make_instr(OP_CLEAR, rand_pc(), rand_pc(), rand_bit(),
                              rand_bit(), rand_bit()));
        made++;
      end else if (kind < 16) begin
        queue_stim(make_instr(OP_READ, rand_pc(), rand_pc(), rand_bit(),
                              rand_bit(), rand_bit()));
        made++;
      end else if (kind < 19) begin
        queue_stim(make_instr(OP_UNUSED, rand_pc(), rand_pc(), rand_bit(),
                              rand_bit(), rand_bit()));
        made++;
      end else if (kind < 55) begin
        nest = $urandom_range(1, 4);
        for (int i = 0; i < nest; i++) begin
          queue_stim(make_instr(OP_STEP, rand_pc(), rand_pc(), 1'b1, 1'b0,
                                ($urandom_range(0, 4) == 0)));
        end
        for (int i = 0; i < nest; i++) begin
          queue_stim(make_instr(OP_STEP, rand_pc(), rand_pc(), 1'b0, 1'b1,
                                ($urandom_range(0, 4) == 0)));
        end
        made += 2 * nest;
      end else begin
        queue_stim(make_instr(OP_STEP, rand_pc(), rand_pc(),
                              ($urandom_range(0, 2) == 0),
                              ($urandom_range(0, 2) == 0),
                              ($urandom_range(0, 3) == 0)));
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. The first phase runs on the register's reset value; the
  // later ones write it to each end of its range and to a random value.
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    add_directed();
    wait_drained();

    write_test_ret(16'hFFFF);
    @(posedge clk);
    add_random(65);
    wait_drained();

    write_test_ret(PC_W'($urandom_range(0, 16'hFFFF)));
    @(posedge clk);
    add_random(65);
    wait_drained();

    write_test_ret(16'h0000);
    @(posedge clk);
    add_random(65);
    wait_drained();

    if (awaited.size() != 0) flag_mismatch("expected results never arrived");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, with every read at full
  // depth and every result held up by the longest stall runs.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
